### rtl/core/erest_pkg.sv
// package for the exposure ratio estimator: constants and types
package erest_pkg;
    localparam int unsigned DEF_LEVELS     = 256;
    localparam int unsigned DEF_CHANNELS   = 3;
    localparam int unsigned DEF_COUNT_BITS = 23;
    localparam int unsigned DEF_FRAC_BITS  = 16;
    localparam int unsigned SUM_BITS       = 48;
    localparam int unsigned LOG_FRAC       = 11;
    localparam int unsigned STOPS_BITS     = 16;
    localparam int unsigned LOG_BITS       = 18;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_ACC,
        ST_LOG,
        ST_OUT
    } t_state;

    typedef enum logic {
        KIND_TABLE = 1'b0,
        KIND_PIXEL = 1'b1
    } t_kind;
endpackage

### rtl/core/exposure_ratio_estimator.sv
// exposure ratio estimator top level: response table, accumulators, log2 result
//
//  channel | dir | payload
//  s_axis  | in  | tdata {table_value,table_level,table_channel,level_b,level_a}, tuser kind,
//          |     | tlast last_sample
//  m_axis  | out | tdata {samples_used,stops_abs}, tuser degenerate
//
// a table write is taken in the idle state, back to back; a pixel item holds the input
// through two table reads, a divider start, NUM_BITS (40) divider steps
// and one accumulate step, skipping the divider when the second radiance is zero.
// a last item then takes the log2 of the sum, then of the count, and an output state.
// reset clears phase, accumulators and output valid; the table holds garbage until written.
// input is taken while a result waits; only the next estimate waits in its output state.
module exposure_ratio_estimator import erest_pkg::*; #(
    parameter int unsigned LEVELS     = DEF_LEVELS,
    parameter int unsigned CHANNELS   = DEF_CHANNELS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // level_a[7:0], level_b[15:8], table_channel[17:16], table_level[25:18],
    // table_value[49:26], zero fill [55:50]
    input  logic [55:0] s_axis_tdata,
    // kind
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // stops_abs[15:0], samples_used[38:16], zero fill [39]
    output logic [39:0] m_axis_tdata,
    // degenerate
    output logic        m_axis_tuser
);
    localparam int unsigned COUNT_BITS = DEF_COUNT_BITS;
    localparam int unsigned FRAC_BITS  = DEF_FRAC_BITS;
    localparam int unsigned VAL_BITS   = 8 + FRAC_BITS;
    localparam int unsigned RATIO_BITS = 16 + FRAC_BITS;
    localparam int unsigned NUM_BITS   = VAL_BITS + FRAC_BITS;
    localparam int unsigned DEPTH      = LEVELS * CHANNELS;
    localparam int unsigned ADDR_BITS  = $clog2(DEPTH);
    localparam int unsigned LV_BITS    = $clog2(LEVELS);
    localparam int unsigned CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned POS_BITS   = 6;
    localparam int unsigned STEP_BITS  = 4;

    // input field split
    logic [7:0]  in_level_a;
    logic [7:0]  in_level_b;
    logic [1:0]  in_tch;
    logic [7:0]  in_tlv;
    logic [23:0] in_tval;
    assign in_level_a = s_axis_tdata[7:0];
    assign in_level_b = s_axis_tdata[15:8];
    assign in_tch     = s_axis_tdata[17:16];
    assign in_tlv     = s_axis_tdata[25:18];
    assign in_tval    = s_axis_tdata[49:26];

    // response table memory
    logic [VAL_BITS-1:0]  mem [DEPTH];
    logic [VAL_BITS-1:0]  r_rd;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_wa;
    logic [ADDR_BITS-1:0] mem_ra;
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= in_tval[VAL_BITS-1:0];
        end
        r_rd <= mem[mem_ra];
    end

    // state
    t_state                r_state, n_state;
    logic [CH_BITS-1:0]    r_phase;
    logic [SUM_BITS-1:0]   r_sum;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [7:0]            r_la, r_lb;
    logic                  r_last;
    logic                  r_rdb;
    logic [VAL_BITS-1:0]   r_qa;
    logic                  r_ovalid;
    logic [STOPS_BITS-1:0] r_ostops;
    logic                  r_odeg;
    logic [COUNT_BITS-1:0] r_oused;

    // log2 unit state
    logic                  r_lsel;
    logic [32:0]           r_m;
    logic [STEP_BITS-1:0]  r_step;
    logic [LOG_BITS-1:0]   r_lsum_log;
    logic [LOG_BITS-1:0]   r_lfrac;
    logic [POS_BITS-1:0]   r_lpos;
    logic                  r_lphase;
    logic [65:0]           r_sq;

    logic                  div_start, div_done;
    logic [NUM_BITS-1:0]   div_quot;

    erest_div #(.NUM_BITS(NUM_BITS), .DEN_BITS(VAL_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  ({r_qa, {FRAC_BITS{1'b0}}}),
        .i_den  (r_rd),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // clamp a pixel level to the table
    function automatic logic [LV_BITS-1:0] clamp_lv(input logic [7:0] lv);
        if (32'(lv) >= LEVELS) return LV_BITS'(LEVELS - 1);
        return LV_BITS'(lv);
    endfunction

    // top set bit position
    logic [SUM_BITS-1:0] lsrc;
    logic [POS_BITS-1:0] lp;
    logic [63:0]         lnorm;
    always_comb begin
        lsrc = r_lsel ? SUM_BITS'(r_cnt) : r_sum;
        lp   = '0;
        for (int i = 0; i < SUM_BITS; i++) begin
            if (lsrc[i]) lp = POS_BITS'(i);
        end
        if (lp >= POS_BITS'(31)) lnorm = 64'(lsrc) >> (lp - POS_BITS'(31));
        else                     lnorm = 64'(lsrc) << (POS_BITS'(31) - lp);
    end

    logic ratio_sat;
    logic [RATIO_BITS-1:0] ratio;
    logic [SUM_BITS:0]     sum_add;
    assign ratio_sat = |div_quot[NUM_BITS-1:RATIO_BITS];
    assign ratio     = ratio_sat ? '1 : div_quot[RATIO_BITS-1:0];
    assign sum_add   = {1'b0, r_sum} + (SUM_BITS+1)'(ratio);

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    // next state and handshake
    always_comb begin
        n_state       = r_state;
        s_axis_tready = (r_state == ST_IDLE);
        mem_we        = 1'b0;
        mem_wa        = ADDR_BITS'(32'(in_tlv) * CHANNELS + 32'(in_tch));
        mem_ra        = ADDR_BITS'(32'(clamp_lv(r_rdb ? r_lb : r_la)) * CHANNELS
                                   + 32'(r_phase));
        div_start     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (s_axis_tuser == KIND_TABLE) begin
                        mem_we = (32'(in_tch) < CHANNELS) && (32'(in_tlv) < LEVELS);
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (r_rdb) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_rd == '0) n_state = ST_ACC;
                else begin
                    div_start = 1'b1;
                    n_state   = ST_ACC;
                end
            end
            ST_ACC: begin
                if (div_done || !r_rdb) begin
                    n_state = r_last ? ST_LOG : ST_IDLE;
                end
            end
            ST_LOG: begin
                if (r_lsel && r_lphase && r_step == STEP_BITS'(LOG_FRAC)) n_state = ST_OUT;
            end
            ST_OUT: begin
                // wait here while the previous result is still held
                if (!r_ovalid || m_axis_tready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= '0;
            r_sum    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_rdb    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && n_state == ST_IDLE) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_rdb <= 1'b0;
                end
                ST_READ: begin
                    r_rdb <= 1'b1;
                end
                ST_DIV: begin
                    // r_rdb now tells whether a division runs
                    r_rdb <= (r_rd != '0);
                    if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
                    if (32'(r_phase) + 1 >= CHANNELS) r_phase <= '0;
                    else r_phase <= r_phase + 1'b1;
                end
                ST_ACC: begin
                    if (div_done) begin
                        r_sum <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
                    end
                end
                ST_OUT: begin
                    if (n_state == ST_IDLE) begin
                        r_sum   <= '0;
                        r_cnt   <= '0;
                        r_phase <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers and log2 iteration
    logic [LOG_BITS-1:0] l_sum_full;
    logic [LOG_BITS:0]   l_diff;
    logic [LOG_BITS:0]   l_abs;
    logic [LOG_BITS-1:0] l_cur;
    assign l_cur      = {r_lpos, {LOG_FRAC{1'b0}}} | r_lfrac;
    assign l_sum_full = r_lsum_log;
    assign l_diff     = {1'b0, l_sum_full} - {1'b0, l_cur}
                        - (LOG_BITS+1)'(FRAC_BITS * 2048);
    assign l_abs      = l_diff[LOG_BITS] ? (~l_diff + 1'b1) : l_diff;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_la   <= in_level_a;
            r_lb   <= in_level_b;
            r_last <= s_axis_tlast;
        end
        // first read data is the radiance of level_a
        if (r_state == ST_READ && r_rdb) r_qa <= r_rd;
        if (r_state == ST_ACC && n_state == ST_LOG) begin
            r_lsel   <= 1'b0;
            r_step   <= '0;
            r_lphase <= 1'b0;
            r_lfrac  <= '0;
            r_m      <= '0;
        end
        if (r_state == ST_LOG) begin
            if (r_step == '0 && !r_lphase) begin
                // load normalized mantissa
                r_lpos   <= lp;
                r_m      <= lnorm[32:0];
                r_lphase <= 1'b1;
                r_step   <= STEP_BITS'(0);
            end else if (r_step != STEP_BITS'(LOG_FRAC)) begin
                if (r_lphase) begin
                    r_sq     <= 66'(r_m) * 66'(r_m);
                    r_lphase <= 1'b0;
                    r_step   <= r_step + 1'b1;
                end
            end
            if (!r_lphase && r_step != '0) begin
                // normalize squared value
                if (r_sq[63]) r_m <= 33'(r_sq >> 32);
                else          r_m <= 33'(r_sq >> 31);
                if (r_step == STEP_BITS'(LOG_FRAC) && !r_lsel) begin
                    // sum done, keep its log and start on the count
                    r_lsum_log <= LOG_BITS'({r_lpos, r_lfrac[LOG_FRAC-2:0], r_sq[63]});
                    r_lsel     <= 1'b1;
                    r_step     <= '0;
                    r_lphase   <= 1'b0;
                    r_lfrac    <= '0;
                end else begin
                    r_lfrac  <= {r_lfrac[LOG_BITS-2:0], r_sq[63]};
                    r_lphase <= 1'b1;
                end
            end
        end
        if (r_state == ST_OUT && n_state == ST_IDLE) begin
            r_odeg   <= (r_cnt == '0) || (r_sum == '0);
            r_oused  <= r_cnt;
            if ((r_cnt == '0) || (r_sum == '0)) r_ostops <= '0;
            else if (|l_abs[LOG_BITS:STOPS_BITS]) r_ostops <= '1;
            else r_ostops <= l_abs[STOPS_BITS-1:0];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(40 - STOPS_BITS - COUNT_BITS){1'b0}}, r_oused, r_ostops};
    assign m_axis_tuser  = r_odeg;
endmodule

### rtl/core/erest_div.sv
// restoring divider, one quotient bit per cycle
module erest_div import erest_pkg::*; #(
    parameter int unsigned NUM_BITS = 40,
    parameter int unsigned DEN_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);
    localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot;
    logic [DEN_BITS:0]   r_rem;
    logic [DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;

    // shift in next numerator bit and try subtract
    always_comb begin
        trial = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        diff  = trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!diff[DEN_BITS]) begin
                r_rem  <= diff;
                r_quot <= {r_quot[NUM_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= trial;
                r_quot <= {r_quot[NUM_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

### tb/sv/exposure_ratio_estimator_tb.sv
// testbench for the exposure ratio estimator: predicted stop estimates checked per estimate
module exposure_ratio_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import erest_pkg::*;

    localparam int unsigned NLEV  = DEF_LEVELS;
    localparam int unsigned NCH   = DEF_CHANNELS;
    localparam int unsigned CBITS = DEF_COUNT_BITS;
    localparam int unsigned FBITS = DEF_FRAC_BITS;
    localparam int unsigned RAND_ITEMS = 200;

    typedef struct packed {
        logic [15:0]      stops;
        logic             degen;
        logic [CBITS-1:0] used;
    } t_estimate;

    typedef struct {
        logic        kind;
        logic [7:0]  lv_a;
        logic [7:0]  lv_b;
        logic        last;
        logic [1:0]  tch;
        logic [7:0]  tlv;
        logic [23:0] tval;
        logic        chk;
        t_estimate   want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tuser;

    exposure_ratio_estimator uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // predictor state
    logic [23:0]      radiance [NLEV*NCH];
    int unsigned      phase;
    logic [47:0]      sum_q;
    logic [CBITS-1:0] count_q;

    t_estimate   pending_est[$];
    logic        pending_chk[$];
    t_estimate   typed_est[$];
    int unsigned errors;
    int unsigned results_seen;
    int unsigned items_sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_recv;
    int unsigned hold_cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // log2 in q.11 by repeated squaring
    function automatic longint log2_q11(logic [63:0] x);
        int          p;
        logic [63:0] m;
        longint      fr;
        p = 63;
        fr = 0;
        while (p > 0 && x[p] == 1'b0) p--;
        if (p >= 31) m = x >> (p - 31);
        else m = x << (31 - p);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
                fr = fr | 1;
                m = m >> 1;
            end
        end
        return longint'(p) * 2048 + fr;
    endfunction

    // advance the predictor by one item, return 1 when an estimate is due
    function automatic bit predict_stops(t_row r, output t_estimate est);
        logic [63:0] qa, qb, ratio, s;
        longint      l;
        int unsigned la, lb;
        est = '0;
        if (r.kind == KIND_TABLE) begin
            if (r.tch < NCH && r.tlv < NLEV)
                radiance[r.tlv * NCH + r.tch] = r.tval;
            return 1'b0;
        end
        la = (r.lv_a >= NLEV) ? NLEV - 1 : r.lv_a;
        lb = (r.lv_b >= NLEV) ? NLEV - 1 : r.lv_b;
        qa = radiance[la * NCH + phase];
        qb = radiance[lb * NCH + phase];
        if (qb != 0) begin
            ratio = (qa << FBITS) / qb;
            if (ratio > 64'hFFFF_FFFF) ratio = 64'hFFFF_FFFF;
            s = {16'd0, sum_q} + ratio;
            sum_q = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
        end
        if (count_q != '1) count_q++;
        phase = (phase + 1 >= NCH) ? 0 : phase + 1;
        if (!r.last) return 1'b0;
        est.used = count_q;
        est.degen = (count_q == 0) || (sum_q == 0);
        if (!est.degen) begin
            l = log2_q11({16'd0, sum_q}) - log2_q11({41'd0, count_q})
                - longint'(FBITS) * 2048;
            if (l < 0) l = -l;
            if (l > 65535) l = 65535;
            est.stops = l[15:0];
        end
        sum_q = '0;
        count_q = '0;
        phase = 0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // drive one item and queue its prediction, valid stays up after acceptance
    task automatic send_item(t_row r);
        t_estimate e;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        if (predict_stops(r, e)) begin
            pending_est.push_back(r.chk ? r.want : e);
            pending_chk.push_back(r.chk);
            typed_est.push_back(e);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tlast  <= r.last;
        s_axis_tdata  <= {6'd0, r.tval, r.tlv, r.tch, r.lv_b, r.lv_a};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic t_row table_row(int ch, int lv, int val);
        t_row r;
        r = '{default: '0};
        r.kind = KIND_TABLE;
        r.tch = ch[1:0];
        r.tlv = lv[7:0];
        r.tval = val[23:0];
        r.lv_a = 8'($urandom);
        r.lv_b = 8'($urandom);
        r.last = 1'($urandom);
        return r;
    endfunction

    function automatic t_row pixel_row(int a, int b, bit lst);
        t_row r;
        r = '{default: '0};
        r.kind = KIND_PIXEL;
        r.lv_a = a[7:0];
        r.lv_b = b[7:0];
        r.last = lst;
        r.tch = 2'($urandom);
        r.tlv = 8'($urandom);
        r.tval = 24'($urandom);
        return r;
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_est.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_recv) begin
            hold_cycles <= 3000;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // compare each accepted estimate with the oldest prediction
    always @(posedge i_clk) begin
        t_estimate exp_e, typ_e;
        bit        chk;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_est.size() == 0) begin
                report_mismatch("unexpected estimate", m_axis_tdata[15:0], 0);
            end else begin
                exp_e = pending_est.pop_front();
                chk = pending_chk.pop_front();
                typ_e = typed_est.pop_front();
                if (chk && typ_e != exp_e)
                    report_mismatch("table row vs predictor", typ_e.stops, exp_e.stops);
                if (m_axis_tdata[15:0] != exp_e.stops)
                    report_mismatch("stops_abs", m_axis_tdata[15:0], exp_e.stops);
                if (m_axis_tuser != exp_e.degen)
                    report_mismatch("degenerate", m_axis_tuser, exp_e.degen);
                if (m_axis_tdata[38:16] != exp_e.used)
                    report_mismatch("samples_used", m_axis_tdata[38:16], exp_e.used);
                if (m_axis_tdata[39] != 1'b0)
                    report_mismatch("tdata fill", m_axis_tdata[39], 0);
            end
        end
    end

    initial begin
        #200ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_row row;
        t_row directed[$];
        int   n;
        errors = 0;
        results_seen = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_recv = 1'b0;
        hold_cycles = 0;
        phase = 0;
        sum_q = '0;
        count_q = '0;
        foreach (radiance[i]) radiance[i] = '0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // fill every table entry so that no unwritten entry is ever read
        for (int lv = 0; lv < NLEV; lv++)
            for (int ch = 0; ch < NCH; ch++)
                send_item(table_row(ch, lv, $urandom_range(24'hFFFFFF, 1)));

        // directed table: extremes and special cases
        directed.push_back(table_row(0, 0, 0));          // zero radiance at level 0
        directed.push_back(table_row(1, 0, 0));
        directed.push_back(table_row(2, 0, 0));
        directed.push_back(table_row(0, 255, 24'hFFFFFF));
        directed.push_back(table_row(1, 255, 24'hFFFFFF));
        directed.push_back(table_row(2, 255, 24'hFFFFFF));
        directed.push_back(table_row(0, 1, 24'h000001));
        directed.push_back(table_row(3, 5, 24'h123456)); // channel out of range, ignored
        // first estimate right after loading, zero sum
        row = pixel_row(0, 0, 1);
        row.chk = 1; row.want = '{stops: 16'd0, degen: 1'b1, used: 23'd1};
        directed.push_back(row);
        // equal levels give ratio one across a full phase cycle
        directed.push_back(pixel_row(255, 255, 0));
        directed.push_back(pixel_row(255, 255, 0));
        row = pixel_row(255, 255, 1);
        row.chk = 1; row.want = '{stops: 16'd0, degen: 1'b0, used: 23'd3};
        directed.push_back(row);
        // zero second radiance counted but not summed
        directed.push_back(pixel_row(255, 0, 0));
        directed.push_back(pixel_row(255, 255, 0));
        directed.push_back(pixel_row(0, 0, 1));
        // saturated ratio and smallest ratio
        directed.push_back(pixel_row(255, 1, 1));
        directed.push_back(pixel_row(1, 255, 1));
        // table writes between pixels leave phase untouched
        directed.push_back(pixel_row(17, 200, 0));
        directed.push_back(table_row(2, 9, $urandom));
        directed.push_back(pixel_row(200, 17, 0));
        directed.push_back(pixel_row(128, 127, 1));
        foreach (directed[i]) send_item(directed[i]);
        wait_drained();

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 77 : (ph == 2 ? 7 : 0);
            recv_stall_pct = (ph == 2 || ph == 3) ? 77 : (ph == 2 ? 7 : 0);
            if (ph == 2) begin
                send_idle_pct = 7;
                recv_stall_pct = 7;
            end
            if (ph == 3) send_idle_pct = 0;
            if (ph == 1) begin
                @(negedge i_clk);
                hold_recv <= 1'b1;
                @(negedge i_clk);
                hold_recv <= 1'b0;
            end
            n = 0;
            while (n < RAND_ITEMS / 4) begin
                if ($urandom_range(99) < 8) begin
                    row = table_row($urandom_range(3), $urandom_range(255),
                                    $urandom_range(24'hFFFFFF, 1));
                end else begin
                    row = pixel_row($urandom_range(255), $urandom_range(255),
                                    $urandom_range(99) < 12);
                    n++;
                end
                send_item(row);
            end
            send_item(pixel_row($urandom_range(255), $urandom_range(255), 1));
            // sender waits for every estimate before the next phase
            s_axis_tvalid <= 1'b0;
            while (pending_est.size() != 0) @(negedge i_clk);
        end

        wait_drained();
        $display("covered %0d items and %0d estimates over four idling phases",
                 items_sent, results_seen);
        $display("including table edges, zero radiance, ratio saturation and a long stall");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/erest_pkg.sv
rtl/core/erest_div.sv
rtl/core/exposure_ratio_estimator.sv
tb/sv/exposure_ratio_estimator_tb.sv
